FILE: design/spx_pkg.sv
// Package for the star-separated packet parser with XOR check.
// Holds the separator byte, field positions and the word and result types.
// No dependencies.
package spx_pkg;

    localparam logic [7:0] SEP_BYTE   = 8'h2A;
    localparam logic [7:0] DIGIT_LO   = 8'h30;
    localparam logic [7:0] DIGIT_HI   = 8'h39;
    localparam logic [31:0] TYPE_ONE  = 32'd1;
    localparam logic [31:0] TYPE_TWO  = 32'd2;
    localparam int OUT_TDATA_W        = 136;

    typedef enum logic [2:0] {
        POS_IDLE    = 3'd0,
        POS_TYPE    = 3'd1,
        POS_SEQ     = 3'd2,
        POS_PAYLOAD = 3'd3,
        POS_CHECK   = 3'd4,
        POS_EXTRA   = 3'd5
    } pos_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_packet;
    } in_word_t;

    typedef struct packed {
        logic        fields_complete;
        logic        check_passed;
        logic        check_done;
        logic [31:0] type_two_total;
        logic [31:0] type_one_total;
        logic [31:0] sequence_number;
        logic [31:0] packet_type;
    } res_t;

endpackage

FILE: design/spx_in_stage.sv
// Input register for the packet parser: holds one received byte word.
// Depends on spx_pkg.
module spx_in_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_valid,
    output logic              s_ready,
    input  spx_pkg::in_word_t s_word,
    input  logic              advance,
    output logic              word_valid,
    output spx_pkg::in_word_t word
);
    import spx_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_word_t word_reg;

    assign s_ready    = !valid_reg || advance;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            word_reg <= s_word;
        end
    end

    assign word_valid = valid_reg;
    assign word       = word_reg;

    a_advance_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> valid_reg)
        else $error("advance without a held word");

endmodule

FILE: design/spx_parser.sv
// Field parser: separator runs, decimal shift-add, payload XOR, type counters
// and checksum compare for one byte per cycle while take is high. Depends on spx_pkg.
module spx_parser
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  spx_pkg::in_word_t word,
    output logic              res_valid,
    output spx_pkg::res_t     res
);
    import spx_pkg::*;

    pos_t        pos_reg, pos_next, pos_new;
    logic        sep_reg, sep_next, sep_new;
    logic        ended_reg, ended_next, ended_new;
    logic [31:0] type_reg, type_next, type_new;
    logic [31:0] seq_reg, seq_next, seq_new;
    logic [31:0] chk_reg, chk_next, chk_new;
    logic [7:0]  xor_reg, xor_next, xor_new;
    logic [31:0] cnt1_reg, cnt1_next, cnt1_new;
    logic [31:0] cnt2_reg, cnt2_next, cnt2_new;
    logic [31:0] acc_sel;
    logic [31:0] shifted;
    logic        is_sep;
    logic        is_digit;
    logic        digit_ok;
    logic        complete;
    logic        is_one;
    logic        is_two;
    logic        last;

    assign last     = word.end_of_packet;
    assign is_sep   = (word.data_byte == SEP_BYTE);
    assign is_digit = (word.data_byte >= DIGIT_LO) && (word.data_byte <= DIGIT_HI);

    always_comb
    begin
        pos_new   = pos_reg;
        sep_new   = sep_reg;
        ended_new = ended_reg;
        type_new  = type_reg;
        seq_new   = seq_reg;
        chk_new   = chk_reg;
        xor_new   = xor_reg;
        acc_sel   = chk_reg;
        shifted   = 32'd0;
        digit_ok  = 1'b0;
        if (is_sep)
        begin
            sep_new = 1'b1;
        end
        else
        begin
            if (sep_reg)
            begin
                sep_new   = 1'b0;
                ended_new = 1'b0;
                if (pos_reg != POS_EXTRA)
                begin
                    pos_new = pos_t'(pos_reg + 3'd1);
                end
            end
            case (pos_new)
                POS_TYPE: acc_sel = type_reg;
                POS_SEQ:  acc_sel = seq_reg;
                default:  acc_sel = chk_reg;
            endcase
            shifted  = {acc_sel[28:0], 3'b000} + {acc_sel[30:0], 1'b0}
                     + {28'd0, word.data_byte[3:0]};
            digit_ok = !ended_new && is_digit;
            case (pos_new) inside
                POS_TYPE, POS_SEQ, POS_CHECK:
                begin
                    if (!digit_ok)
                    begin
                        ended_new = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            case (pos_new)
                POS_TYPE:
                begin
                    if (digit_ok)
                    begin
                        type_new = shifted;
                    end
                end
                POS_SEQ:
                begin
                    if (digit_ok)
                    begin
                        seq_new = shifted;
                    end
                end
                POS_CHECK:
                begin
                    if (digit_ok)
                    begin
                        chk_new = shifted;
                    end
                end
                POS_PAYLOAD:
                begin
                    xor_new = xor_reg ^ word.data_byte;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign complete = (pos_new >= POS_CHECK);
    assign is_one   = (type_new == TYPE_ONE);
    assign is_two   = (type_new == TYPE_TWO);
    assign cnt1_new = cnt1_reg + {31'd0, is_one};
    assign cnt2_new = cnt2_reg + {31'd0, is_two};

    assign res_valid           = take && last;
    assign res.packet_type     = type_new;
    assign res.sequence_number = seq_new;
    assign res.type_one_total  = cnt1_new;
    assign res.type_two_total  = cnt2_new;
    assign res.check_done      = complete && is_two;
    assign res.check_passed    = complete && is_two
                               && (({24'd0, xor_new} ^ type_new ^ seq_new) == chk_new);
    assign res.fields_complete = complete;

    always_comb
    begin
        pos_next   = pos_reg;
        sep_next   = sep_reg;
        ended_next = ended_reg;
        type_next  = type_reg;
        seq_next   = seq_reg;
        chk_next   = chk_reg;
        xor_next   = xor_reg;
        cnt1_next  = cnt1_reg;
        cnt2_next  = cnt2_reg;
        if (take && last)
        begin
            pos_next   = POS_IDLE;
            sep_next   = 1'b1;
            ended_next = 1'b0;
            type_next  = 32'd0;
            seq_next   = 32'd0;
            chk_next   = 32'd0;
            xor_next   = 8'd0;
            cnt1_next  = cnt1_new;
            cnt2_next  = cnt2_new;
        end
        else if (take)
        begin
            pos_next   = pos_new;
            sep_next   = sep_new;
            ended_next = ended_new;
            type_next  = type_new;
            seq_next   = seq_new;
            chk_next   = chk_new;
            xor_next   = xor_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= POS_IDLE;
            sep_reg   <= 1'b1;
            ended_reg <= 1'b0;
            type_reg  <= 32'd0;
            seq_reg   <= 32'd0;
            chk_reg   <= 32'd0;
            xor_reg   <= 8'd0;
            cnt1_reg  <= 32'd0;
            cnt2_reg  <= 32'd0;
        end
        else
        begin
            pos_reg   <= pos_next;
            sep_reg   <= sep_next;
            ended_reg <= ended_next;
            type_reg  <= type_next;
            seq_reg   <= seq_next;
            chk_reg   <= chk_next;
            xor_reg   <= xor_next;
            cnt1_reg  <= cnt1_next;
            cnt2_reg  <= cnt2_next;
        end
    end

    a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> (pos_reg == POS_IDLE) && sep_reg && (xor_reg == 8'd0))
        else $error("parse state not cleared after last byte");

    a_pass_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (!res.check_passed || res.check_done))
        else $error("check passed without a check");

    a_done_needs_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (!res.check_done || res.fields_complete))
        else $error("check done on an incomplete packet");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !(take && last) |=> $stable(cnt1_reg) && $stable(cnt2_reg))
        else $error("type counter moved without a last byte");

endmodule

FILE: design/spx_out_stage.sv
// Result register for the packet parser: holds one result word until taken.
// Depends on spx_pkg.
module spx_out_stage
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load,
    input  spx_pkg::res_t                     res,
    output logic                              ready,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [spx_pkg::OUT_TDATA_W-1:0]   m_data
);
    import spx_pkg::*;

    logic valid_reg;
    logic valid_next;
    res_t res_reg;

    assign ready      = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = {{(OUT_TDATA_W - $bits(res_t)){1'b0}}, res_reg};

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!valid_reg || m_ready))
        else $error("result overwritten before it was taken");

endmodule

FILE: design/star_packet_parse_and_xor_check.sv
// Top level of the star-separated packet parser with XOR check.
// Depends on spx_pkg, spx_in_stage, spx_parser and spx_out_stage.
//
// Takes one datagram byte per word on the slave side, one word per cycle
// while no final byte waits for the result register; tlast marks the final
// byte. Each byte is parsed in a single step between the input register and
// the result register, so the block keeps pace with the input. A final
// byte's result word is loaded into the result register for the master side
// and carries the type, sequence number, running type-1 and type-2 counts
// and the check flags. Bytes before the last produce no output word.
// The running counts survive across packets and clear only on reset.
module star_packet_parse_and_xor_check
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [7:0] data_byte
    input  logic [7:0]                          s_axis_tdata,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [31:0] packet_type, [63:32] sequence_number, [95:64] type_one_total,
    // [127:96] type_two_total, [128] check_done, [129] check_passed,
    // [130] fields_complete, [135:131] zero
    output logic [spx_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
    import spx_pkg::*;

    in_word_t s_word;
    in_word_t word;
    logic     word_valid;
    logic     advance;
    logic     out_ready;
    logic     res_valid;
    res_t     res;

    assign s_word.data_byte     = s_axis_tdata;
    assign s_word.end_of_packet = s_axis_tlast;

    assign advance = word_valid && (!word.end_of_packet || out_ready);

    spx_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_word     (s_word),
        .advance    (advance),
        .word_valid (word_valid),
        .word       (word)
    );

    spx_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (advance),
        .word      (word),
        .res_valid (res_valid),
        .res       (res)
    );

    spx_out_stage u_out_stage
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (res_valid),
        .res     (res),
        .ready   (out_ready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_data  (m_axis_tdata)
    );

endmodule
